// File: rtl/rpv_pkg.sv
// Shared types, constants and helpers of the result packet validator.
package rpv_pkg;

    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_fault;
    typedef logic [4:0]  t_index;
    typedef logic [1:0]  t_cfg_index;
    typedef logic [5:0]  t_rate;
    typedef logic [6:0]  t_lag_limit;

    localparam t_word MAGIC_WORD  = 32'h3153_5350;
    localparam t_word HEADER_WORD = 32'h1a01_0001;

    // Register indexes of the configuration port
    localparam t_cfg_index CFG_SAMPLE_RATE = 2'd0;
    localparam t_cfg_index CFG_ACTIVE_GEN  = 2'd1;

    localparam t_rate RATE_RESET = 6'd15;

    // Fault codes, lower code wins
    localparam t_fault FAULT_NONE   = 4'd0;
    localparam t_fault FAULT_MAGIC  = 4'd1;
    localparam t_fault FAULT_HEADER = 4'd2;
    localparam t_fault FAULT_WORD2  = 4'd3;
    localparam t_fault FAULT_GEN    = 4'd4;
    localparam t_fault FAULT_CENTER = 4'd5;
    localparam t_fault FAULT_LAG    = 4'd6;
    localparam t_fault FAULT_WINNER = 4'd7;
    localparam t_fault FAULT_METRIC = 4'd8;
    localparam t_fault FAULT_WORD19 = 4'd9;

    // Word positions inside a packet
    localparam t_index IDX_MAGIC      = 5'd0;
    localparam t_index IDX_HEADER     = 5'd1;
    localparam t_index IDX_WORD2      = 5'd2;
    localparam t_index IDX_CIDX_LO    = 5'd3;
    localparam t_index IDX_CIDX_HI    = 5'd4;
    localparam t_index IDX_CENTER_LO  = 5'd5;
    localparam t_index IDX_CENTER_HI  = 5'd6;
    localparam t_index IDX_LAG        = 5'd7;
    localparam t_index IDX_WINNER_LO  = 5'd8;
    localparam t_index IDX_WINNER_HI  = 5'd9;
    localparam t_index IDX_GEN        = 5'd10;
    localparam t_index IDX_METRIC0_LO = 5'd15;
    localparam t_index IDX_METRIC0_HI = 5'd16;
    localparam t_index IDX_METRIC1_LO = 5'd17;
    localparam t_index IDX_METRIC1_HI = 5'd18;
    localparam t_index IDX_WORD19     = 5'd19;

    // 30 * floor(rate / 15) for a 6-bit rate
    function automatic t_lag_limit lag_limit(input t_rate rate);
        t_lag_limit lim;
        if (rate < 6'd15) begin
            lim = 7'd0;
        end else if (rate < 6'd30) begin
            lim = 7'd30;
        end else if (rate < 6'd45) begin
            lim = 7'd60;
        end else if (rate < 6'd60) begin
            lim = 7'd90;
        end else begin
            lim = 7'd120;
        end
        return lim;
    endfunction

    // Signed 48-bit value {high[15:0], low} is strictly positive
    function automatic logic metric_positive(input t_word low, input t_word high);
        return !high[15] && ((high[15:0] != 16'd0) || (low != 32'd0));
    endfunction

endpackage

// File: rtl/result_packet_validator.sv
// Result packet validator: per-word checks of a fixed-length packet, one verdict per packet.
// The verdict is registered and presented in the cycle after the last word is accepted.
// One word per cycle while the input is not stalled; every check is made of compares, and for the winner a
//   64-bit add, on the current word and the held operands, done in the cycle the word is accepted.
// The verdict sits in an output register; the input stalls only while that register is
//   full and the downstream side stalls.
// Reset (i_rst_n low, synchronous): counter at word 0, no fault, no pending verdict,
//   rate 15, generation 0. Held operands are not reset.
module result_packet_validator #(
    parameter int PKT_LEN = 26
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  rpv_pkg::t_cfg_index     i_cfg_index,
    input  rpv_pkg::t_word          i_cfg_data,
    // word input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  rpv_pkg::t_word          i_word_value,
    input  logic                    i_first_word,
    // verdict output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_packet_ok,
    output rpv_pkg::t_fault         o_fault_code
);
    import rpv_pkg::*;

    localparam t_index LAST_IDX = t_index'(PKT_LEN - 1);

    // configuration
    t_rate      r_rate;
    t_word      r_active_gen;

    // packet state
    t_index     r_count,  n_count;
    t_fault     r_fault,  n_fault;
    logic [63:0] r_center_idx, n_center_idx;
    logic [63:0] r_center,     n_center;
    t_word      r_lag,        n_lag;
    t_word      r_winner_lo,  n_winner_lo;
    t_word      r_metric_lo,  n_metric_lo;

    // verdict register
    logic       r_out_valid, n_out_valid;
    logic       r_ok;
    t_fault     r_code;

    logic       in_fire;
    t_index     idx;
    logic       last_word;

    // lag check operands
    logic signed [31:0] lag_s;
    logic signed [31:0] lim_s;
    logic [63:0]        winner_sum;

    // keep the lowest nonzero code
    function automatic t_fault note_fault(input t_fault cur, input t_fault code);
        return ((cur == FAULT_NONE) || (code < cur)) ? code : cur;
    endfunction

    // input is held off only while a verdict waits on a stalled output
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_fire    = i_in_valid && !o_in_stall;

    // flag forces word 0, otherwise the running counter
    assign idx       = i_first_word ? IDX_MAGIC : r_count;
    assign last_word = (idx >= LAST_IDX);

    assign lag_s      = $signed(i_word_value);
    assign lim_s      = $signed({25'd0, lag_limit(r_rate)});
    // winner = center + sign-extended lag, modulo 2^64
    assign winner_sum = r_center + {{32{r_lag[31]}}, r_lag};

    always_comb begin
        n_center_idx = r_center_idx;
        n_center     = r_center;
        n_lag        = r_lag;
        n_winner_lo  = r_winner_lo;
        n_metric_lo  = r_metric_lo;
        // a new packet starts clean, whether by flag or by wrap
        n_fault      = (idx == IDX_MAGIC) ? FAULT_NONE : r_fault;

        case (idx)
            IDX_MAGIC: begin
                if (i_word_value != MAGIC_WORD) n_fault = note_fault(n_fault, FAULT_MAGIC);
            end
            IDX_HEADER: begin
                if (i_word_value != HEADER_WORD) n_fault = note_fault(n_fault, FAULT_HEADER);
            end
            IDX_WORD2: begin
                if (i_word_value == 32'd0) n_fault = note_fault(n_fault, FAULT_WORD2);
            end
            IDX_CIDX_LO: begin
                n_center_idx = {32'd0, i_word_value};
            end
            IDX_CIDX_HI: begin
                n_center_idx = {i_word_value, r_center_idx[31:0]};
            end
            IDX_CENTER_LO: begin
                n_center = {32'd0, i_word_value};
            end
            IDX_CENTER_HI: begin
                n_center = {i_word_value, r_center[31:0]};
                if ({i_word_value, r_center[31:0]} != r_center_idx) begin
                    n_fault = note_fault(n_fault, FAULT_CENTER);
                end
            end
            IDX_LAG: begin
                n_lag = i_word_value;
                if ((lag_s > lim_s) || (lag_s < -lim_s)) begin
                    n_fault = note_fault(n_fault, FAULT_LAG);
                end
            end
            IDX_WINNER_LO: begin
                n_winner_lo = i_word_value;
            end
            IDX_WINNER_HI: begin
                if ({i_word_value, r_winner_lo} != winner_sum) begin
                    n_fault = note_fault(n_fault, FAULT_WINNER);
                end
            end
            IDX_GEN: begin
                if ((i_word_value == 32'd0) || (i_word_value != r_active_gen)) begin
                    n_fault = note_fault(n_fault, FAULT_GEN);
                end
            end
            IDX_METRIC0_LO, IDX_METRIC1_LO: begin
                n_metric_lo = i_word_value;
            end
            IDX_METRIC0_HI, IDX_METRIC1_HI: begin
                if (!metric_positive(r_metric_lo, i_word_value)) begin
                    n_fault = note_fault(n_fault, FAULT_METRIC);
                end
            end
            IDX_WORD19: begin
                if (i_word_value != 32'd0) n_fault = note_fault(n_fault, FAULT_WORD19);
            end
            default: begin
            end
        endcase

        n_count = last_word ? IDX_MAGIC : (idx + 5'd1);

        // a new verdict always finds the register free or draining
        if (in_fire && last_word) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate       <= RATE_RESET;
            r_active_gen <= 32'd0;
            r_count      <= IDX_MAGIC;
            r_fault      <= FAULT_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_SAMPLE_RATE)) r_rate <= i_cfg_data[5:0];
            if (i_cfg_we && (i_cfg_index == CFG_ACTIVE_GEN))  r_active_gen <= i_cfg_data;
            if (in_fire) begin
                r_count <= n_count;
                r_fault <= n_fault;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // held operands and verdict payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_center_idx <= n_center_idx;
            r_center     <= n_center;
            r_lag        <= n_lag;
            r_winner_lo  <= n_winner_lo;
            r_metric_lo  <= n_metric_lo;
            if (last_word) begin
                r_ok   <= (n_fault == FAULT_NONE);
                r_code <= n_fault;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_packet_ok  = r_ok;
    assign o_fault_code = r_code;

endmodule

// File: test/tb.sv
// Testbench of the result packet validator: predicts every verdict from the words sent and checks it.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpv_pkg::*;

    localparam int PKT_LEN      = 26;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 4;         // verdict lands in the cycle after the last word
    localparam int PRINT_LIMIT  = 200;

    typedef struct packed {
        logic   ok;
        t_fault code;
    } verdict_t;

    // Tracks the packet position and the held operands, and keeps the verdicts still owed.
    class verdict_scoreboard;
        t_rate       rate;
        t_word       generation;
        t_index      word_idx;
        t_fault      lead_fault;
        logic [63:0] center_idx_word;
        logic [63:0] center_word;
        t_word       lag_word;
        t_word       winner_lo;
        t_word       metric_lo;
        verdict_t    expected_verdicts[$];
        int          errors;

        function new();
            rate       = RATE_RESET;
            generation = '0;
            word_idx   = '0;
            lead_fault = FAULT_NONE;
            errors     = 0;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
            errors++;
        endtask

        function void set_reg(t_cfg_index idx, t_word data);
            case (idx)
                CFG_SAMPLE_RATE: rate = data[5:0];
                CFG_ACTIVE_GEN:  generation = data;
                default: ;
            endcase
        endfunction

        // lowest code wins
        function void flag(t_fault code);
            if (lead_fault == FAULT_NONE || code < lead_fault) begin
                lead_fault = code;
            end
        endfunction

        // One accepted word transaction.
        function void take_word(t_word w, logic first);
            t_index      idx;
            int          lim;
            logic [63:0] winner_sum;
            idx = first ? IDX_MAGIC : word_idx;
            lim = 30 * (int'(rate) / 15);
            if (idx == IDX_MAGIC) begin
                lead_fault = FAULT_NONE;
            end
            case (idx)
                IDX_MAGIC:     if (w != MAGIC_WORD) flag(FAULT_MAGIC);
                IDX_HEADER:    if (w != HEADER_WORD) flag(FAULT_HEADER);
                IDX_WORD2:     if (w == '0) flag(FAULT_WORD2);
                IDX_CIDX_LO:   center_idx_word = {32'd0, w};
                IDX_CIDX_HI:   center_idx_word[63:32] = w;
                IDX_CENTER_LO: center_word = {32'd0, w};
                IDX_CENTER_HI: begin
                    center_word[63:32] = w;
                    if (center_word != center_idx_word) flag(FAULT_CENTER);
                end
                IDX_LAG: begin
                    lag_word = w;
                    if ($signed(w) > lim || $signed(w) < -lim) flag(FAULT_LAG);
                end
                IDX_WINNER_LO: winner_lo = w;
                IDX_WINNER_HI: begin
                    winner_sum = center_word + {{32{lag_word[31]}}, lag_word};
                    if ({w, winner_lo} != winner_sum) flag(FAULT_WINNER);
                end
                IDX_GEN:       if (w == '0 || w != generation) flag(FAULT_GEN);
                IDX_METRIC0_LO, IDX_METRIC1_LO: metric_lo = w;
                IDX_METRIC0_HI, IDX_METRIC1_HI: begin
                    // signed 48-bit value must be strictly positive
                    if (w[15] || {w[15:0], metric_lo} == 48'd0) flag(FAULT_METRIC);
                end
                IDX_WORD19:    if (w != '0) flag(FAULT_WORD19);
                default: ;
            endcase
            if (int'(idx) >= PKT_LEN - 1) begin
                expected_verdicts.push_back('{lead_fault == FAULT_NONE, lead_fault});
                word_idx = '0;
            end else begin
                word_idx = idx + 1'b1;
            end
        endfunction

        // One accepted verdict transaction.
        task check_verdict(logic ok, t_fault code);
            verdict_t want;
            if (expected_verdicts.size() == 0) begin
                report($sformatf("verdict with none pending: ok=%0b code=%0d", ok, code));
                return;
            end
            want = expected_verdicts.pop_front();
            if (ok !== want.ok) begin
                report($sformatf("packet_ok %0b, want %0b", ok, want.ok));
            end
            if (code !== want.code) begin
                report($sformatf("fault_code %0d, want %0d", code, want.code));
            end
        endtask

        task flush_leftover();
            while (expected_verdicts.size() > 0) begin
                void'(expected_verdicts.pop_front());
                report("verdict never delivered");
            end
        endtask
    endclass

    // ---------------------------------------------------------------- DUT hookup
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    t_cfg_index i_cfg_index  = CFG_SAMPLE_RATE;
    t_word      i_cfg_data   = '0;
    logic       i_in_valid   = 1'b0;
    t_word      i_word_value = '0;
    logic       i_first_word = 1'b0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_packet_ok;
    t_fault     o_fault_code;

    result_packet_validator #(
        .PKT_LEN(PKT_LEN)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_word_value(i_word_value),
        .i_first_word(i_first_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_packet_ok (o_packet_ok),
        .o_fault_code(o_fault_code)
    );

    verdict_scoreboard sb = new();

    // calm: a stretch where neither side inserts gaps
    logic  calm = 1'b0;
    int    cycle_count = 0;
    t_word pkt [PKT_LEN];

    always #10 i_clk = ~i_clk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("result_packet_validator verification failed");
            $finish;
        end
    end

    // Downstream side: random stall, changed on the falling edge only.
    always @(negedge i_clk) begin
        i_out_stall = !calm && ($urandom_range(99) < 26);
    end

    // Verdicts are taken at the rising edge, before the DUT registers update.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_verdict(o_packet_ok, o_fault_code);
        end
    end

    // ---------------------------------------------------------------- drivers
    // All driver tasks start and end on a falling edge.
    task automatic send_word(t_word w, logic first);
        while (!calm && $urandom_range(99) < 26) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_word_value = w;
        i_first_word = first;
        // payload holds until a rising edge with no stall
        do @(posedge i_clk); while (o_in_stall);
        sb.take_word(w, first);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, t_word data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Let every owed verdict arrive, then wait out DRAIN_CYCLES.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (sb.expected_verdicts.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- packet builder
    function automatic t_word nonzero_mask();
        t_word m;
        m = $urandom_range(1) ? (32'd1 << $urandom_range(31)) : t_word'($urandom);
        if (m == '0) m = 32'd1;
        return m;
    endfunction

    function automatic void set_winner();
        logic [63:0] sum;
        sum = {pkt[IDX_CENTER_HI], pkt[IDX_CENTER_LO]} + {{32{pkt[IDX_LAG][31]}}, pkt[IDX_LAG]};
        pkt[IDX_WINNER_LO] = sum[31:0];
        pkt[IDX_WINNER_HI] = sum[63:32];
    endfunction

    // Well-formed packet under the current settings (generation zero still fails).
    function automatic void build_packet();
        logic [63:0] center;
        int          lim;
        int          lag;
        t_index      lo;
        for (int i = 0; i < PKT_LEN; i++) pkt[i] = $urandom;
        pkt[IDX_MAGIC]  = MAGIC_WORD;
        pkt[IDX_HEADER] = HEADER_WORD;
        if (pkt[IDX_WORD2] == '0) pkt[IDX_WORD2] = 32'd1;
        case ($urandom_range(7))
            0:       center = '0;
            1:       center = '1;   // winner sum wraps past 2^64 with a positive lag
            default: center = {t_word'($urandom), t_word'($urandom)};
        endcase
        {pkt[IDX_CIDX_HI], pkt[IDX_CIDX_LO]}     = center;
        {pkt[IDX_CENTER_HI], pkt[IDX_CENTER_LO]} = center;
        lim = 30 * (int'(sb.rate) / 15);
        case ($urandom_range(3))
            0:       lag = -lim;
            1:       lag = lim;
            default: lag = int'($urandom_range(2 * lim)) - lim;
        endcase
        pkt[IDX_LAG] = t_word'(lag);
        set_winner();
        pkt[IDX_GEN] = sb.generation;
        for (int m = 0; m < 2; m++) begin
            lo = m ? IDX_METRIC1_LO : IDX_METRIC0_LO;
            pkt[lo + 1][15] = 1'b0;
            case ($urandom_range(5))
                0: begin   // smallest positive value
                    pkt[lo + 1][15:0] = 16'd0;
                    pkt[lo] = 32'd1;
                end
                1: begin   // largest positive value
                    pkt[lo + 1][15:0] = 16'h7fff;
                    pkt[lo] = '1;
                end
                default: if ({pkt[lo + 1][15:0], pkt[lo]} == 48'd0) pkt[lo] = 32'd1;
            endcase
        end
        pkt[IDX_WORD19] = '0;
    endfunction

    // Break the check that gives the named fault code.
    function automatic void break_packet(t_fault kind);
        int     lim;
        t_word  mag;
        t_index lo;
        lim = 30 * (int'(sb.rate) / 15);
        case (kind)
            FAULT_MAGIC:  pkt[IDX_MAGIC]  ^= nonzero_mask();
            FAULT_HEADER: pkt[IDX_HEADER] ^= nonzero_mask();
            FAULT_WORD2:  pkt[IDX_WORD2]   = '0;
            FAULT_GEN: begin
                if ($urandom_range(1)) pkt[IDX_GEN] = '0;
                else pkt[IDX_GEN] ^= nonzero_mask();
            end
            FAULT_CENTER: begin
                if ($urandom_range(1)) pkt[IDX_CENTER_LO] ^= nonzero_mask();
                else pkt[IDX_CENTER_HI] ^= nonzero_mask();
            end
            FAULT_LAG: begin
                case ($urandom_range(2))
                    0:       mag = t_word'(lim + 1 + $urandom_range(1000));
                    1:       mag = 32'h8000_0000;   // most negative lag
                    default: mag = t_word'(lim + 1);
                endcase
                pkt[IDX_LAG] = $urandom_range(1) ? -mag : mag;
                // half the time the winner follows the bad lag so only the lag check fails
                if ($urandom_range(1)) set_winner();
            end
            FAULT_WINNER: begin
                if ($urandom_range(1)) pkt[IDX_WINNER_LO] ^= nonzero_mask();
                else pkt[IDX_WINNER_HI] ^= nonzero_mask();
            end
            FAULT_METRIC: begin
                lo = $urandom_range(1) ? IDX_METRIC1_LO : IDX_METRIC0_LO;
                if ($urandom_range(1)) begin
                    pkt[lo + 1][15] = 1'b1;     // negative
                end else begin
                    pkt[lo + 1][15:0] = 16'd0;  // exactly zero
                    pkt[lo] = '0;
                end
            end
            FAULT_WORD19: pkt[IDX_WORD19] = nonzero_mask();
            default: ;
        endcase
    endfunction

    // Send the first n words of pkt. Word 0 always carries the flag when the counter
    // is mid-packet; at a boundary the flag is optional since the counter has wrapped.
    task automatic send_packet(int n, logic flag0);
        for (int i = 0; i < n; i++) begin
            send_word(pkt[i], (i == 0) ? (flag0 || sb.word_idx != IDX_MAGIC) : 1'b0);
        end
    endtask

    // Finish a partial packet with filler so the next phase starts on a boundary.
    task automatic close_packet();
        while (sb.word_idx != IDX_MAGIC) send_word($urandom, 1'b0);
    endtask

    // Mostly packets with random content and 0..3 broken checks; the rest are
    // truncated packets and loose noise words.
    task automatic run_random(int n_words);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                build_packet();
                if ($urandom_range(99) >= 35) begin
                    repeat ($urandom_range(1, 3)) begin
                        break_packet(t_fault'($urandom_range(FAULT_MAGIC, FAULT_WORD19)));
                    end
                end
                send_packet(PKT_LEN, $urandom_range(1));
                sent += PKT_LEN;
            end else if (pick < 87) begin
                // truncated: a later restart flag may cut into the middle of this one
                build_packet();
                len = $urandom_range(1, PKT_LEN - 1);
                send_packet(len, $urandom_range(1));
                sent += len;
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) send_word($urandom, $urandom_range(7) == 0);
                sent += len;
            end
        end
        close_packet();
    endtask

    // ---------------------------------------------------------------- stimulus
    t_rate phase_rate [6] = '{6'd0, 6'd63, 6'd30, 6'd60, 6'd14, 6'd44};

    initial begin
        t_word gen;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset values: rate 15, generation 0 -> a well-formed packet is still rejected.
        build_packet();
        send_packet(PKT_LEN, 1'b1);
        wait_idle();
        write_reg(CFG_ACTIVE_GEN, 32'd1);

        // Clean packet, then one packet per check.
        build_packet();
        send_packet(PKT_LEN, 1'b1);
        for (int k = FAULT_MAGIC; k <= FAULT_WORD19; k++) begin
            build_packet();
            break_packet(t_fault'(k));
            send_packet(PKT_LEN, 1'b0);   // word 0 taken after the wrap, no flag
        end
        // Every check broken at once: the magic fault must win.
        build_packet();
        for (int k = FAULT_WORD19; k >= FAULT_MAGIC; k--) break_packet(t_fault'(k));
        send_packet(PKT_LEN, 1'b1);
        // Restart flag in mid-packet drops the partial packet without a verdict.
        build_packet();
        send_packet(12, 1'b1);
        build_packet();
        send_packet(PKT_LEN, 1'b1);

        // Random phases under a spread of settings, extremes included.
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            // upper data bits carry junk; only the low six bits form the rate
            write_reg(CFG_SAMPLE_RATE, ($urandom & ~32'h3f) | 32'(phase_rate[p]));
            case (p)
                0:       gen = '1;
                2:       gen = '0;
                3:       gen = 32'd1;
                default: gen = $urandom;
            endcase
            write_reg(CFG_ACTIVE_GEN, gen);
            calm = (p == 3);
            run_random(60);
        end
        calm = 1'b0;

        wait_idle();
        sb.flush_leftover();
        if (sb.errors == 0) begin
            $display("result_packet_validator verification clean");
        end else begin
            $display("result_packet_validator verification failed");
        end
        $finish;
    end

endmodule
